// ===== rtl/saabb_pkg.sv =====
// ----------------------------------------------------------------------------
// Swept box collision test package
// Shared types, constants and the divider step for the swept box test.
// ----------------------------------------------------------------------------
package saabb_pkg;

	localparam int unsigned QBITS       = 33;
	localparam int unsigned DIV_STEPS   = 3;
	localparam int unsigned DIV_STAGES  = QBITS / DIV_STEPS;
	localparam int unsigned FT_W        = 31;
	localparam logic [FT_W-1:0] FT_RESET = FT_W'(1092);

	typedef struct packed {
		logic [QBITS-1:0] rem;
		logic [QBITS-1:0] nq;
		logic [QBITS-1:0] uv;
		logic             neg;
		logic             sat;
	} lane_t;

	typedef struct packed {
		logic                  hit_now;
		logic                  miss;
		logic                  updx;
		logic                  updy;
		logic [3:0][33:0]      num;
		logic [1:0][33:0]      vel;
	} front_t;

	typedef struct packed {
		logic             hit_now;
		logic             miss;
		logic             updx;
		logic             updy;
		lane_t [3:0]      lane;
	} div_t;

	typedef struct packed {
		logic                   hit_now;
		logic                   miss;
		logic                   updx;
		logic                   updy;
		logic [3:0][31:0]       tm;
	} times_t;

	typedef struct packed {
		logic               hit_now;
		logic               miss;
		logic signed [31:0] tf;
		logic signed [31:0] tl;
	} window_t;

	function automatic lane_t div_step(input lane_t l);
		lane_t     r;
		logic [33:0] t;
		logic      b;
		r = l;
		t = {l.rem, l.nq[QBITS-1]};
		b = (t >= {1'b0, l.uv});
		if (b) begin
			t = t - {1'b0, l.uv};
		end
		r.rem = t[QBITS-1:0];
		r.nq  = {l.nq[QBITS-2:0], b};
		return r;
	endfunction

endpackage

// ===== rtl/swept_aabb_collision_test.sv =====
// ----------------------------------------------------------------------------
// Swept box collision test
// Tests two moving 2D boxes in Q16.16 for contact within one frame.
// Two front stages, eleven divider stages of three quotient bits each, then
// time, window and output registers form the pipeline.
// Throughput is one beat per cycle; the four entry and exit divisions run in
// parallel pipelined dividers. A stall at the output holds every stage.
// Reset clears all valid bits and loads frame_time with 1092.
// ----------------------------------------------------------------------------
module swept_aabb_collision_test (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [saabb_pkg::FT_W-1:0] frame_time,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [31:0] a_min_x,
	input  logic signed [31:0] a_min_y,
	input  logic signed [31:0] a_max_x,
	input  logic signed [31:0] a_max_y,
	input  logic signed [31:0] a_vel_x,
	input  logic signed [31:0] a_vel_y,
	input  logic signed [31:0] b_min_x,
	input  logic signed [31:0] b_min_y,
	input  logic signed [31:0] b_max_x,
	input  logic signed [31:0] b_max_y,
	input  logic signed [31:0] b_vel_x,
	input  logic signed [31:0] b_vel_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit
);
	import saabb_pkg::*;

	logic [FT_W-1:0] ft_q;
	logic            adv;

	front_t  front_d, f_s1;
	div_t    div_d, d_s2;
	div_t    dv_s3 [DIV_STAGES];
	div_t    dv_d  [DIV_STAGES];
	times_t  times_d, t_s4;
	window_t win_d, w_s5;
	logic    v_s1, v_s2, v_s4, v_s5;
	logic [DIV_STAGES-1:0] dv_v_s3;
	logic    hit_q, out_valid_q;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;
	assign hit       = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ft_q <= FT_RESET;
		end else if (cfg_valid) begin
			ft_q <= frame_time;
		end
	end

	always_comb begin
		logic signed [33:0] aminx, aminy, amaxx, amaxy, bminx, bminy, bmaxx, bmaxy;
		logic signed [33:0] vx, vy;
		logic mx, my;
		aminx = 34'(a_min_x); aminy = 34'(a_min_y);
		amaxx = 34'(a_max_x); amaxy = 34'(a_max_y);
		bminx = 34'(b_min_x); bminy = 34'(b_min_y);
		bmaxx = 34'(b_max_x); bmaxy = 34'(b_max_y);
		vx = 34'(b_vel_x) - 34'(a_vel_x);
		vy = 34'(b_vel_y) - 34'(a_vel_y);
		front_d.hit_now = !(amaxx < bminx || amaxy < bminy || bmaxx < aminx || bmaxy < aminy);
		if (vx[33]) begin
			mx = aminx > bmaxx;
			front_d.updx = amaxx < bminx;
			front_d.num[0] = amaxx - bminx;
			front_d.num[1] = aminx - bmaxx;
		end else begin
			mx = (vx == 34'sd0) ? (amaxx < bminx || aminx > bmaxx) : (amaxx < bminx);
			front_d.updx = (vx != 34'sd0) && (aminx > bmaxx);
			front_d.num[0] = aminx - bmaxx;
			front_d.num[1] = amaxx - bminx;
		end
		if (vy[33]) begin
			my = aminy > bmaxy;
			front_d.updy = amaxy < bminy;
			front_d.num[2] = amaxy - bminy;
			front_d.num[3] = aminy - bmaxy;
		end else begin
			my = (vy == 34'sd0) ? (amaxy < bminy || aminy > bmaxy) : (amaxy < bminy);
			front_d.updy = (vy != 34'sd0) && (aminy > bmaxy);
			front_d.num[2] = aminy - bmaxy;
			front_d.num[3] = amaxy - bminy;
		end
		front_d.miss   = mx || my;
		front_d.vel[0] = vx;
		front_d.vel[1] = vy;
	end

	always_comb begin
		logic [33:0] d, v, ud, uv;
		div_d.hit_now = f_s1.hit_now;
		div_d.miss    = f_s1.miss;
		div_d.updx    = f_s1.updx;
		div_d.updy    = f_s1.updy;
		for (int l = 0; l < 4; l++) begin
			d  = f_s1.num[l];
			v  = f_s1.vel[l/2];
			ud = d[33] ? -d : d;
			uv = v[33] ? -v : v;
			div_d.lane[l].neg = d[33] ^ v[33];
			div_d.lane[l].uv  = uv[QBITS-1:0];
			div_d.lane[l].rem = {17'b0, ud[32:17]};
			div_d.lane[l].nq  = {ud[16:0], 16'b0};
			div_d.lane[l].sat = {17'b0, ud[32:17]} >= uv[QBITS-1:0];
		end
	end

	always_comb begin
		div_t cur;
		for (int k = 0; k < DIV_STAGES; k++) begin
			cur = (k == 0) ? d_s2 : dv_s3[k-1];
			for (int s = 0; s < DIV_STEPS; s++) begin
				for (int l = 0; l < 4; l++) begin
					cur.lane[l] = div_step(cur.lane[l]);
				end
			end
			dv_d[k] = cur;
		end
	end

	always_comb begin
		div_t        last;
		logic [32:0] q;
		last = dv_s3[DIV_STAGES-1];
		times_d.hit_now = last.hit_now;
		times_d.miss    = last.miss;
		times_d.updx    = last.updx;
		times_d.updy    = last.updy;
		for (int l = 0; l < 4; l++) begin
			q = last.lane[l].nq;
			if (last.lane[l].neg) begin
				if (last.lane[l].sat || q > 33'h080000000) begin
					times_d.tm[l] = 32'h80000000;
				end else begin
					times_d.tm[l] = -q[31:0];
				end
			end else begin
				if (last.lane[l].sat || q > 33'h07FFFFFFF) begin
					times_d.tm[l] = 32'h7FFFFFFF;
				end else begin
					times_d.tm[l] = q[31:0];
				end
			end
		end
	end

	always_comb begin
		logic signed [31:0] tf, tl;
		tf = 32'sd0;
		tl = signed'({1'b0, ft_q});
		if (t_s4.updx) begin
			if (signed'(t_s4.tm[0]) > tf) tf = signed'(t_s4.tm[0]);
			if (signed'(t_s4.tm[1]) < tl) tl = signed'(t_s4.tm[1]);
		end
		if (t_s4.updy) begin
			if (signed'(t_s4.tm[2]) > tf) tf = signed'(t_s4.tm[2]);
			if (signed'(t_s4.tm[3]) < tl) tl = signed'(t_s4.tm[3]);
		end
		win_d.hit_now = t_s4.hit_now;
		win_d.miss    = t_s4.miss;
		win_d.tf      = tf;
		win_d.tl      = tl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			dv_v_s3     <= '0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			dv_v_s3     <= {dv_v_s3[DIV_STAGES-2:0], v_s2};
			v_s4        <= dv_v_s3[DIV_STAGES-1];
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1  <= front_d;
			d_s2  <= div_d;
			for (int k = 0; k < DIV_STAGES; k++) begin
				dv_s3[k] <= dv_d[k];
			end
			t_s4  <= times_d;
			w_s5  <= win_d;
			hit_q <= w_s5.hit_now || (!w_s5.miss && (w_s5.tf <= w_s5.tl));
		end
	end

	a_now_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s5 && w_s5.hit_now) |=> hit)
		else $error("overlapping boxes did not report a hit");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while output stalled");

	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !v_s5) |=> !out_valid)
		else $error("output beat without a matching item");

endmodule

// ===== tb/saabb_checker.sv =====
// ----------------------------------------------------------------------------
// Swept box collision checker
// Watches the configuration, input and result channels of the swept box test.
// For every accepted input beat it predicts the hit flag and queues it; every
// accepted result beat is compared with the oldest queued prediction.
// ----------------------------------------------------------------------------
module saabb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [saabb_pkg::FT_W-1:0] frame_time,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic signed [31:0] a_min_x,
	input  logic signed [31:0] a_min_y,
	input  logic signed [31:0] a_max_x,
	input  logic signed [31:0] a_max_y,
	input  logic signed [31:0] a_vel_x,
	input  logic signed [31:0] a_vel_y,
	input  logic signed [31:0] b_min_x,
	input  logic signed [31:0] b_min_y,
	input  logic signed [31:0] b_max_x,
	input  logic signed [31:0] b_max_y,
	input  logic signed [31:0] b_vel_x,
	input  logic signed [31:0] b_vel_y,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        hit,
	output int          errors,
	output int          pending
);

	logic [saabb_pkg::FT_W-1:0] window_len;
	bit hit_queue[$];
	int unsigned beat_no;

	function automatic longint contact_time(input longint d, input longint v);
		bit neg;
		longint ud, uv, q;
		neg = (d < 0) != (v < 0);
		ud = (d < 0) ? -d : d;
		uv = (v < 0) ? -v : v;
		q = (ud <<< 16) / uv;
		if (d == 0) begin
			return 0;
		end
		if (neg) begin
			if (q > 64'sh80000000) q = 64'sh80000000;
			return -q;
		end
		if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
		return q;
	endfunction

	function automatic bit narrow_axis(input longint amin, input longint amax,
			input longint bmin, input longint bmax, input longint v,
			inout longint tf, inout longint tl);
		longint t_in, t_out;
		if (v < 0) begin
			if (amin > bmax) return 0;
			if (amax < bmin) begin
				t_in  = contact_time(amax - bmin, v);
				t_out = contact_time(amin - bmax, v);
				if (t_in > tf) tf = t_in;
				if (t_out < tl) tl = t_out;
			end
		end else if (v > 0) begin
			if (amax < bmin) return 0;
			if (amin > bmax) begin
				t_in  = contact_time(amin - bmax, v);
				t_out = contact_time(amax - bmin, v);
				if (t_in > tf) tf = t_in;
				if (t_out < tl) tl = t_out;
			end
		end else begin
			if (amax < bmin || amin > bmax) return 0;
		end
		return 1;
	endfunction

	function automatic bit predict_hit();
		longint tf, tl;
		tf = 0;
		tl = longint'(window_len);
		if (!(a_max_x < b_min_x || a_max_y < b_min_y || b_max_x < a_min_x ||
				b_max_y < a_min_y)) begin
			return 1;
		end
		if (!narrow_axis(a_min_x, a_max_x, b_min_x, b_max_x,
				longint'(b_vel_x) - longint'(a_vel_x), tf, tl)) begin
			return 0;
		end
		if (!narrow_axis(a_min_y, a_max_y, b_min_y, b_max_y,
				longint'(b_vel_y) - longint'(a_vel_y), tf, tl)) begin
			return 0;
		end
		return tf <= tl;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit want;
		if (!arst_n) begin
			window_len = saabb_pkg::FT_RESET;
			hit_queue.delete();
			errors = 0;
			beat_no = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_len = frame_time;
			end
			if (in_valid && in_ready) begin
				hit_queue.push_back(predict_hit());
			end
			if (out_valid && out_ready) begin
				beat_no++;
				if (hit_queue.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("result beat %0d arrived with nothing expected", beat_no);
					end
				end else begin
					want = hit_queue.pop_front();
					if (hit !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("result beat %0d: hit expected %0b, got %0b",
								beat_no, want, hit);
						end
					end
				end
			end
		end
		pending = hit_queue.size();
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Swept box collision testbench
// Drives directed and random box pairs into the swept box test under varying
// frame times and handshake idling, including one long output stall, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [saabb_pkg::FT_W-1:0] frame_time = '0;
	logic        in_valid = 0;
	logic        in_ready;
	logic signed [31:0] a_min_x = 0, a_min_y = 0, a_max_x = 0, a_max_y = 0;
	logic signed [31:0] a_vel_x = 0, a_vel_y = 0;
	logic signed [31:0] b_min_x = 0, b_min_y = 0, b_max_x = 0, b_max_y = 0;
	logic signed [31:0] b_vel_x = 0, b_vel_y = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic        hit;
	int          errors;
	int          pending;

	int  tx_idle_pct = 30;
	int  rx_idle_pct = 55;
	bit  stall_req = 0;
	int  stall_left = 0;

	localparam logic signed [31:0] S_MIN = 32'sh80000000;
	localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;

	always #5 clk = ~clk;

	swept_aabb_collision_test uut (.*);

	saabb_checker chk (.*);

	always @(posedge clk) begin
		if (stall_req) begin
			stall_req = 0;
			stall_left = 300;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic offer_pair(input logic signed [31:0] f[12]);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		a_min_x <= f[0]; a_min_y <= f[1]; a_max_x <= f[2]; a_max_y <= f[3];
		a_vel_x <= f[4]; a_vel_y <= f[5];
		b_min_x <= f[6]; b_min_y <= f[7]; b_max_x <= f[8]; b_max_y <= f[9];
		b_vel_x <= f[10]; b_vel_y <= f[11];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_frame_time(input logic [saabb_pkg::FT_W-1:0] v);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1;
		frame_time <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	function automatic logic signed [31:0] spread_val();
		logic [31:0] m;
		case ($urandom_range(9))
			0: return $urandom;
			1: return S_MIN;
			2: return S_MAX;
			default: begin
				m = $urandom & ((32'h1 << $urandom_range(30)) - 1);
				return $urandom_range(1) ? -$signed(m) : $signed(m);
			end
		endcase
	endfunction

	task automatic random_pair();
		logic signed [31:0] f[12];
		logic signed [31:0] gx, gy;
		if ($urandom_range(9) < 2) begin
			foreach (f[i]) f[i] = $urandom_range(3) == 0 ? spread_val() : $urandom;
		end else begin
			f[0] = spread_val() >>> $urandom_range(8);
			f[1] = spread_val() >>> $urandom_range(8);
			f[2] = f[0] + ($urandom & 32'h3FFFF);
			f[3] = f[1] + ($urandom & 32'h3FFFF);
			gx = spread_val() >>> $urandom_range(10);
			gy = spread_val() >>> $urandom_range(10);
			f[6] = $urandom_range(1) ? f[2] + gx : f[0] - gx;
			f[7] = $urandom_range(1) ? f[3] + gy : f[1] - gy;
			f[8] = f[6] + ($urandom & 32'h3FFFF);
			f[9] = f[7] + ($urandom & 32'h3FFFF);
			f[4] = spread_val();
			f[5] = spread_val();
			f[10] = $urandom_range(3) == 0 ? f[4] : spread_val();
			f[11] = $urandom_range(3) == 0 ? f[5] : spread_val();
			if ($urandom_range(7) == 0) begin
				gx = f[0]; f[0] = f[2]; f[2] = gx;
			end
		end
		offer_pair(f);
	endtask

	initial begin
		logic signed [31:0] d[12];
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Touching edges, then plain overlap.
		d = '{0, 0, 100, 100, 0, 0, 100, 0, 200, 100, 0, 0};
		offer_pair(d);
		d = '{0, 0, 100, 100, 5, 5, 50, 50, 150, 150, -5, -5};
		offer_pair(d);
		// Separated on x with no relative motion, separated on y likewise.
		d = '{0, 0, 100, 100, 7, 0, 200, 0, 300, 100, 7, 0};
		offer_pair(d);
		d = '{0, 0, 100, 100, 0, 3, 0, 200, 100, 300, 0, 3};
		offer_pair(d);
		// Moving apart from either side.
		d = '{0, 0, 100, 100, 0, 0, 200, 0, 300, 100, 65536, 0};
		offer_pair(d);
		d = '{0, 0, 100, 100, 0, 0, -300, 0, -200, 100, -65536, 0};
		offer_pair(d);
		// Closing from the high side and the low side, fast and slow.
		d = '{0, 0, 100, 100, 0, 0, 200, 0, 300, 100, -65536000, 0};
		offer_pair(d);
		d = '{0, 0, 100, 100, 0, 0, -300, 0, -200, 100, 65536000, 0};
		offer_pair(d);
		d = '{0, 0, 100, 100, 0, 0, 200, 0, 300, 100, -1, 0};
		offer_pair(d);
		d = '{0, 0, 100, 100, 0, 0, 0, 300, 100, 400, 0, -65536000};
		offer_pair(d);
		// Closing on both axes.
		d = '{0, 0, 10, 10, 0, 0, 1000, 20, 1010, 30, -65536000, -655360};
		offer_pair(d);
		d = '{0, 0, 10, 10, 0, 0, 20, 20, 30, 30, -65536000, -65536000};
		offer_pair(d);
		// Extreme coordinates and velocities, saturating times.
		d = '{S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX,
			S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN};
		offer_pair(d);
		d = '{S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN,
			S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX};
		offer_pair(d);
		d = '{S_MIN, 0, S_MIN, 0, 0, 0, S_MAX, 0, S_MAX, 0, -1, 0};
		offer_pair(d);
		d = '{S_MIN, 0, S_MIN, 0, 1, 0, S_MAX, 0, S_MAX, 0, 0, 0};
		offer_pair(d);
		d = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1};
		offer_pair(d);
		// Inverted boxes.
		d = '{100, 100, 0, 0, 0, 0, 50, 50, 40, 40, 0, 0};
		offer_pair(d);
		d = '{100, 0, 0, 100, 0, 0, 300, 0, 200, 100, -65536, 0};
		offer_pair(d);

		write_frame_time(31'h7FFFFFFF);
		tx_idle_pct = 30;
		rx_idle_pct = 55;
		repeat (400) random_pair();

		write_frame_time(31'h0);
		repeat (100) random_pair();

		write_frame_time(31'($urandom));
		tx_idle_pct = 55;
		rx_idle_pct = 30;
		repeat (300) random_pair();

		write_frame_time(31'd65536);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		stall_req = 1;
		repeat (300) random_pair();

		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/saabb_pkg.sv
rtl/swept_aabb_collision_test.sv
tb/saabb_checker.sv
tb/tb.sv
